// File: src/bfa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap frame allocator package
// Shared constants, operation codes and saturating counter helpers.
// ----------------------------------------------------------------------------
package bfa_pkg;

  // Default geometry of the frame store.
  localparam int unsigned FRAME_COUNT = 262144;
  localparam int unsigned FRAME_BYTES = 4096;
  localparam int unsigned WORD_BITS   = 32;

  // Field widths of the request and result channels.
  localparam int unsigned OPCODE_W    = 2;
  localparam int unsigned BYTE_ADDR_W = 32;
  localparam int unsigned GRANT_W     = 30;
  localparam int unsigned CNT_W       = 19;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Operation codes.
  localparam logic [OPCODE_W-1:0] OP_ALLOCATE   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_FREE       = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_ADD_USABLE = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_RESERVE    = 2'd3;

  // Counters stick at their upper limit.
  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? CNT_MAX : c + CNT_W'(1);
  endfunction

  // Counters stick at zero.
  function automatic logic [CNT_W-1:0] cnt_dec(input logic [CNT_W-1:0] c);
    return (c == '0) ? '0 : c - CNT_W'(1);
  endfunction

endpackage

// File: src/bfa_if.sv
// ----------------------------------------------------------------------------
// Bitmap frame allocator channels
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface bfa_req_if;
  logic                               valid;
  logic                               ready;
  logic [bfa_pkg::OPCODE_W-1:0]       opcode;
  logic [bfa_pkg::BYTE_ADDR_W-1:0]    byte_address;

  modport source (output valid, output opcode, output byte_address, input ready);
  modport sink   (input valid, input opcode, input byte_address, output ready);
endinterface

interface bfa_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [bfa_pkg::GRANT_W-1:0]        granted_address;
  logic                               success;
  logic [bfa_pkg::CNT_W-1:0]          free_count;
  logic [bfa_pkg::CNT_W-1:0]          total_count;

  modport source (output valid, output granted_address, output success,
                  output free_count, output total_count, input ready);
  modport sink   (input valid, input granted_address, input success,
                  input free_count, input total_count, output ready);
endinterface

// File: src/bfa_word_scan.sv
// ----------------------------------------------------------------------------
// Bitmap word scan
// Finds the lowest clear bit of one bitmap word, that is the lowest free frame.
// ----------------------------------------------------------------------------
module bfa_word_scan #(
  parameter  int unsigned WORD_BITS = bfa_pkg::WORD_BITS,
  localparam int unsigned BIT_W     = $clog2(WORD_BITS)
) (
  input  logic [WORD_BITS-1:0] word,
  output logic                 found,
  output logic [BIT_W-1:0]     index
);

  // Walk from the top so that the lowest clear bit wins.
  always_comb begin
    index = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        index = BIT_W'(i);
      end
    end
  end

  assign found = ~&word;

endmodule

// File: src/bitmap_frame_allocator_unit.sv
// Free, add-usable and reserve read one bitmap word on accept and write it
// back, if the request succeeds, when the result is loaded. Allocate also
// steps the search cursor over every fully used bitmap word; the cursor only
// moves forward past full words. A new request is taken only in the idle
// state, once the previous result has been loaded. After reset the bitmap is
// swept to all-used, one word per cycle (8192 words at the default size), with no request taken.
// ----------------------------------------------------------------------------
// Bitmap frame allocator
// First-fit physical frame allocator over a used/free bitmap held in a
// synchronous memory, with free and usable frame counters.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_unit #(
  parameter int unsigned FRAME_COUNT = bfa_pkg::FRAME_COUNT,
  parameter int unsigned FRAME_BYTES = bfa_pkg::FRAME_BYTES,
  parameter int unsigned WORD_BITS   = bfa_pkg::WORD_BITS
) (
  input  logic      clk,
  input  logic      rst,
  bfa_req_if.sink   req,
  bfa_rsp_if.source rsp
);

  // Geometry. Frame size and word width are powers of two, so the frame
  // number and the bit position are plain slices of the byte address.
  localparam int unsigned NWORDS     = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW         = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned BIT_W      = $clog2(WORD_BITS);
  localparam int unsigned PAGE_SHIFT = $clog2(FRAME_BYTES);
  localparam int unsigned FRAME_W    = bfa_pkg::BYTE_ADDR_W - PAGE_SHIFT;
  localparam int unsigned CNT_W      = bfa_pkg::CNT_W;

  // Controller states.
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  // The bitmap itself: one bit per frame, a set bit means the frame is used.
  logic [WORD_BITS-1:0] mem [NWORDS];

  logic [1:0]              state, state_next;
  logic [AW-1:0]           clr_addr, clr_next;
  logic [AW:0]             hint, hint_next;
  logic [CNT_W-1:0]        avail_frames, free_next;
  logic [CNT_W-1:0]        usable_frames, usable_next;

  // Request held while it is being worked on.
  logic [bfa_pkg::OPCODE_W-1:0] op;
  logic [FRAME_W-1:0]           frame;
  logic                         in_range;

  // Memory ports.
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  // Result register.
  logic                        out_valid;
  logic [bfa_pkg::GRANT_W-1:0] out_granted;
  logic                        out_success;
  logic                        finish;
  logic [bfa_pkg::GRANT_W-1:0] res_granted;
  logic                        res_success;

  logic [FRAME_W-1:0]   req_frame;
  logic [AW-1:0]        req_word;
  logic [AW-1:0]        word;
  logic [BIT_W-1:0]     bit_pos;
  logic [WORD_BITS-1:0] bit_mask;
  logic                 hint_empty;
  logic                 can_out;
  logic                 scan_found;
  logic [BIT_W-1:0]     scan_index;
  logic [AW+BIT_W-1:0]  grant_frame;

  assign req_frame  = req.byte_address[bfa_pkg::BYTE_ADDR_W-1:PAGE_SHIFT];
  assign req_word   = AW'(req_frame >> BIT_W);
  assign word       = AW'(frame >> BIT_W);
  assign bit_pos    = frame[BIT_W-1:0];
  assign bit_mask   = WORD_BITS'(1) << bit_pos;

  // The cursor sits on the lowest word that may still hold a free frame;
  // every word below it is fully used. At the top it means nothing is free.
  assign hint_empty = (hint == (AW+1)'(NWORDS));

  // A new result may be written when the result register is empty or is
  // being taken at this edge.
  assign can_out    = !out_valid || rsp.ready;

  assign req.ready  = (state == ST_IDLE);

  bfa_word_scan #(
    .WORD_BITS (WORD_BITS)
  ) u_scan (
    .word  (rd_data),
    .found (scan_found),
    .index (scan_index)
  );

  assign grant_frame = {hint[AW-1:0], scan_index};

  always_comb begin
    state_next  = state;
    clr_next    = clr_addr;
    hint_next   = hint;
    free_next   = avail_frames;
    usable_next = usable_frames;
    rd_en       = 1'b0;
    rd_addr     = hint[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = word;
    wr_data     = rd_data;
    finish      = 1'b0;
    res_granted = '0;
    res_success = 1'b0;

    case (state)
      ST_CLEAR: begin
        // Sweep the whole bitmap to all-used, one word per cycle.
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '1;
        if (clr_addr == AW'(NWORDS - 1)) begin
          state_next = ST_IDLE;
        end else begin
          clr_next = clr_addr + AW'(1);
        end
      end

      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_EXEC;
          if (req.opcode == bfa_pkg::OP_ALLOCATE) begin
            rd_en   = !hint_empty;
            rd_addr = hint[AW-1:0];
          end else begin
            rd_en   = 1'b1;
            rd_addr = req_word;
          end
        end
      end

      ST_EXEC: begin
        case (op)
          bfa_pkg::OP_ALLOCATE: begin
            if (hint_empty) begin
              finish = can_out;
            end else if (!scan_found) begin
              // Word under the cursor is full: step on and fetch the next one.
              hint_next = hint + (AW+1)'(1);
              rd_en     = (hint_next != (AW+1)'(NWORDS));
              rd_addr   = hint_next[AW-1:0];
            end else begin
              finish      = can_out;
              res_success = 1'b1;
              res_granted = bfa_pkg::GRANT_W'({grant_frame, {PAGE_SHIFT{1'b0}}});
              wr_en       = can_out;
              wr_addr     = hint[AW-1:0];
              wr_data     = rd_data | (WORD_BITS'(1) << scan_index);
              if (can_out) begin
                free_next = bfa_pkg::cnt_dec(avail_frames);
              end
            end
          end

          bfa_pkg::OP_FREE: begin
            finish      = can_out;
            res_success = in_range && rd_data[bit_pos];
            wr_data     = rd_data & ~bit_mask;
            if (can_out && res_success) begin
              wr_en     = 1'b1;
              free_next = bfa_pkg::cnt_inc(avail_frames);
              if ((AW+1)'(word) < hint) begin
                hint_next = (AW+1)'(word);
              end
            end
          end

          bfa_pkg::OP_ADD_USABLE: begin
            // Counts rise even when the frame was already free.
            finish      = can_out;
            res_success = in_range;
            wr_data     = rd_data & ~bit_mask;
            if (can_out && res_success) begin
              wr_en       = 1'b1;
              free_next   = bfa_pkg::cnt_inc(avail_frames);
              usable_next = bfa_pkg::cnt_inc(usable_frames);
              if ((AW+1)'(word) < hint) begin
                hint_next = (AW+1)'(word);
              end
            end
          end

          default: begin
            // Reserve: only a free frame changes state.
            finish      = can_out;
            res_success = in_range && !rd_data[bit_pos];
            wr_data     = rd_data | bit_mask;
            if (can_out && res_success) begin
              wr_en     = 1'b1;
              free_next = bfa_pkg::cnt_dec(avail_frames);
            end
          end
        endcase

        if (finish) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Bitmap memory with a registered read port. Reads are issued on accept or
  // while the cursor steps; writes only on completion or during the sweep,
  // so the two never meet in one cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      hint          <= (AW+1)'(NWORDS);
      avail_frames  <= '0;
      usable_frames <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      clr_addr      <= clr_next;
      hint          <= hint_next;
      avail_frames  <= free_next;
      usable_frames <= usable_next;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op       <= req.opcode;
      frame    <= req_frame;
      in_range <= bfa_pkg::BYTE_ADDR_W'(req_frame) < bfa_pkg::BYTE_ADDR_W'(FRAME_COUNT);
    end
    if (finish) begin
      out_granted <= res_granted;
      out_success <= res_success;
    end
  end

  // The counters only change when a result is loaded, so they can be shown
  // directly alongside the result register.
  assign rsp.valid           = out_valid;
  assign rsp.granted_address = out_granted;
  assign rsp.success         = out_success;
  assign rsp.free_count      = avail_frames;
  assign rsp.total_count     = usable_frames;

  // A non-zero address is only ever handed out by a successful allocation.
  a_grant_means_success: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.granted_address != '0)) |-> rsp.success)
    else $error("granted address without success");

  // An accepted request always moves the controller into execution.
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == ST_EXEC))
    else $error("accepted request not executed");

  // The cursor never passes the end of the bitmap.
  a_hint_bound: assert property (@(posedge clk) disable iff (rst)
    hint <= (AW+1)'(NWORDS))
    else $error("search cursor out of range");

  // The sweep only ends after the last word has been written.
  a_clear_complete: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == ST_CLEAR && state != ST_CLEAR && !$past(rst))
      |-> ($past(clr_addr) == AW'(NWORDS - 1)))
    else $error("clearing sweep ended early");

  // The memory is never written while waiting for a request.
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state != ST_IDLE))
    else $error("bitmap write while idle");

endmodule

// File: tb/sv/bitmap_frame_allocator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator testbench
// Drives allocate, free, add-usable and reserve requests into the allocator.
// A table of directed requests comes first, followed by random traffic in
// three idling phases. Every result is checked against a behavioural frame map
// kept in the testbench.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_unit_tb;
  import bfa_pkg::*;

  // Geometry of the behavioural frame map, matching the default block size.
  localparam int unsigned MAP_WORDS = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;

  // Most random traffic stays in the lowest frames. The allocate search only
  // walks forward over full words, so a small working set keeps it short.
  localparam int unsigned SMALL_FRAMES = 1024;

  localparam int unsigned RANDOM_REQUESTS = 780;
  localparam int unsigned DIRECTED_ROWS   = 29;

  // An allocate can walk the whole bitmap, 8192 words, and the sweep after
  // reset takes as long again. The limit allows several times that.
  localparam int unsigned STALL_LIMIT  = 50000;
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned MAX_REPORTS  = 10;

  // One result as it appears on the result channel.
  typedef struct packed {
    logic [GRANT_W-1:0] granted_address;
    logic               success;
    logic [CNT_W-1:0]   free_count;
    logic [CNT_W-1:0]   total_count;
  } grant_result_t;

  // One row of the directed table. Where typed is set, the result written in
  // the row is the one checked; otherwise the frame map supplies it.
  typedef struct packed {
    bit                     typed;
    logic [OPCODE_W-1:0]    op;
    logic [BYTE_ADDR_W-1:0] addr;
    grant_result_t          want;
  } frame_step_t;

  logic clk;
  logic rst;

  bfa_req_if req_ch ();
  bfa_rsp_if rsp_ch ();

  bitmap_frame_allocator_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Behavioural frame map: one bit per frame, 1 meaning used, plus the two
  // saturating counters and a true count of clear bits for shaping stimulus.
  logic [WORD_BITS-1:0] used_words [MAP_WORDS];
  logic [CNT_W-1:0]     free_tally;
  logic [CNT_W-1:0]     usable_tally;
  int unsigned          open_frames;

  grant_result_t pending_results [$];
  int unsigned   granted_frames [$];
  frame_step_t   directed_steps [DIRECTED_ROWS];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches;
  int unsigned stalled_cycles;

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = ~clk;
  end

  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] count_down(input logic [CNT_W-1:0] c);
    return (c == '0) ? c : c - 1'b1;
  endfunction

  // Sets or clears one frame's bit and keeps the true free-bit count in step.
  function automatic void mark_frame(input int unsigned frame, input bit used);
    if (used_words[frame / WORD_BITS][frame % WORD_BITS] != used) begin
      if (used) begin
        open_frames--;
      end else begin
        open_frames++;
      end
    end
    used_words[frame / WORD_BITS][frame % WORD_BITS] = used;
  endfunction

  // Applies one request to the frame map and returns the result it causes.
  function automatic grant_result_t apply_frame_request(
    input logic [OPCODE_W-1:0] op,
    input logic [BYTE_ADDR_W-1:0] addr
  );
    int unsigned   frame;
    int unsigned   w;
    int unsigned   b;
    int unsigned   slot;
    bit            found;
    bit            in_range;
    bit            is_used;
    grant_result_t res;
    frame    = addr / FRAME_BYTES;
    in_range = frame < FRAME_COUNT;
    is_used  = in_range ? used_words[frame / WORD_BITS][frame % WORD_BITS] : 1'b1;
    found    = 1'b0;
    res      = '0;
    case (op)
      OP_ALLOCATE: begin
        // First fit: the lowest clear bit in the lowest word that has one.
        for (w = 0; w < MAP_WORDS && !found; w++) begin
          if (~used_words[w] != '0) begin
            for (b = 0; b < WORD_BITS && !found; b++) begin
              slot = w * WORD_BITS + b;
              if (slot < FRAME_COUNT && !used_words[w][b]) begin
                found = 1'b1;
                mark_frame(slot, 1'b1);
                free_tally          = count_down(free_tally);
                res.granted_address = GRANT_W'(longint'(slot) * FRAME_BYTES);
                res.success         = 1'b1;
              end
            end
          end
        end
      end
      OP_FREE: begin
        if (in_range && is_used) begin
          mark_frame(frame, 1'b0);
          free_tally  = count_up(free_tally);
          res.success = 1'b1;
        end
      end
      OP_ADD_USABLE: begin
        // No check on the bit: a repeated add raises both counts again.
        if (in_range) begin
          mark_frame(frame, 1'b0);
          free_tally   = count_up(free_tally);
          usable_tally = count_up(usable_tally);
          res.success  = 1'b1;
        end
      end
      default: begin
        if (in_range && !is_used) begin
          mark_frame(frame, 1'b1);
          free_tally  = count_down(free_tally);
          res.success = 1'b1;
        end
      end
    endcase
    res.free_count  = free_tally;
    res.total_count = usable_tally;
    return res;
  endfunction

  // Presents one request from a falling edge, holds it until the rising edge
  // at which it is accepted, records its expected result and returns on the
  // next falling edge. Valid is left high so that back-to-back requests keep
  // it high without a glitch.
  task automatic send_request(
    input  logic [OPCODE_W-1:0]    op,
    input  logic [BYTE_ADDR_W-1:0] addr,
    input  bit                     use_want,
    input  grant_result_t          want,
    output grant_result_t          predicted
  );
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.opcode       <= op;
    req_ch.byte_address <= addr;
    @(posedge clk);
    while (!req_ch.ready) begin
      @(posedge clk);
    end
    predicted = apply_frame_request(op, addr);
    pending_results.push_back(use_want ? want : predicted);
    @(negedge clk);
  endtask

  // Compares one accepted result, field by field, with the oldest expectation.
  task automatic check_result();
    grant_result_t want;
    grant_result_t got;
    got.granted_address = rsp_ch.granted_address;
    got.success         = rsp_ch.success;
    got.free_count      = rsp_ch.free_count;
    got.total_count     = rsp_ch.total_count;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("unexpected result: addr %h ok %b free %0d total %0d",
                 got.granted_address, got.success, got.free_count, got.total_count);
      end
    end else begin
      want = pending_results.pop_front();
      if (got.granted_address !== want.granted_address || got.success !== want.success ||
          got.free_count !== want.free_count || got.total_count !== want.total_count) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("mismatch: want addr %h ok %b free %0d total %0d, got addr %h ok %b free %0d total %0d",
                   want.granted_address, want.success, want.free_count, want.total_count,
                   got.granted_address, got.success, got.free_count, got.total_count);
        end
      end
    end
  endtask

  // The receiver decides its readiness for the next edge on each falling edge.
  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Results are taken at the rising edge at which valid and ready are high.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      check_result();
    end
  end

  // The watchdog ends the run when nothing moves on either channel for too
  // long, which covers a hung search as well as a lost result.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    int unsigned   pick;
    int unsigned   frame;
    int unsigned   offset;
    int unsigned   slot;
    logic [BYTE_ADDR_W-1:0] addr;
    logic [OPCODE_W-1:0]    op;
    grant_result_t predicted;

    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.opcode       = OP_ALLOCATE;
    req_ch.byte_address = '0;
    rsp_ch.ready        = 1'b0;
    send_idle_pct       = 29;
    recv_idle_pct       = 54;
    mismatches          = 0;
    stalled_cycles      = 0;
    free_tally          = '0;
    usable_tally        = '0;
    open_frames         = 0;
    foreach (used_words[i]) begin
      used_words[i] = '1;
    end

    // The table walks the special cases from the reset state onwards. Frame
    // 262143 is the top frame: address 0x3FFF_F000. Addresses with bit 30 or
    // 31 set name frames past the end and must be ignored.
    directed_steps = '{
      // Allocate straight after reset finds nothing free; its address is ignored.
      '{1'b1, OP_ALLOCATE,   32'hFFFF_FFFF, '{30'h0,        1'b0, 19'd0, 19'd0}},
      // Every frame starts used, so a free of frame zero succeeds.
      '{1'b1, OP_FREE,       32'h0000_0000, '{30'h0,        1'b1, 19'd1, 19'd0}},
      '{1'b1, OP_RESERVE,    32'h0000_0FFF, '{30'h0,        1'b1, 19'd0, 19'd0}},
      // Reserving a frame that is already used is ignored.
      '{1'b1, OP_RESERVE,    32'h0000_0000, '{30'h0,        1'b0, 19'd0, 19'd0}},
      '{1'b1, OP_FREE,       32'h4000_0000, '{30'h0,        1'b0, 19'd0, 19'd0}},
      '{1'b1, OP_ADD_USABLE, 32'hFFFF_FFFF, '{30'h0,        1'b0, 19'd0, 19'd0}},
      '{1'b1, OP_RESERVE,    32'h8000_0000, '{30'h0,        1'b0, 19'd0, 19'd0}},
      // A repeated add on one frame raises both counts twice.
      '{1'b1, OP_ADD_USABLE, 32'h0000_0FFF, '{30'h0,        1'b1, 19'd1, 19'd1}},
      '{1'b1, OP_ADD_USABLE, 32'h0000_0000, '{30'h0,        1'b1, 19'd2, 19'd2}},
      // Frame zero is granted at address zero; only success marks it.
      '{1'b1, OP_ALLOCATE,   32'h0000_0000, '{30'h0,        1'b1, 19'd1, 19'd2}},
      '{1'b1, OP_FREE,       32'h0000_0800, '{30'h0,        1'b1, 19'd2, 19'd2}},
      // Freeing a frame that is already free is ignored.
      '{1'b1, OP_FREE,       32'h0000_0000, '{30'h0,        1'b0, 19'd2, 19'd2}},
      '{1'b1, OP_ADD_USABLE, 32'h3FFF_F000, '{30'h0,        1'b1, 19'd3, 19'd3}},
      '{1'b1, OP_ADD_USABLE, 32'h3FFF_FFFF, '{30'h0,        1'b1, 19'd4, 19'd4}},
      '{1'b1, OP_ADD_USABLE, 32'h0000_1000, '{30'h0,        1'b1, 19'd5, 19'd5}},
      '{1'b1, OP_ALLOCATE,   32'h0000_0000, '{30'h0,        1'b1, 19'd4, 19'd5}},
      '{1'b1, OP_ALLOCATE,   32'h0000_0000, '{30'h0001000,  1'b1, 19'd3, 19'd5}},
      // The next grant has to search the whole bitmap up to the top frame.
      '{1'b1, OP_ALLOCATE,   32'h0000_0000, '{30'h3FFFF000, 1'b1, 19'd2, 19'd5}},
      // The free count now overstates what is free, but no frame is left.
      '{1'b1, OP_ALLOCATE,   32'h0000_0000, '{30'h0,        1'b0, 19'd2, 19'd5}},
      '{1'b1, OP_FREE,       32'h3FFF_F123, '{30'h0,        1'b1, 19'd3, 19'd5}},
      '{1'b1, OP_RESERVE,    32'h3FFF_F000, '{30'h0,        1'b1, 19'd2, 19'd5}},
      '{1'b1, OP_RESERVE,    32'h3FFF_FFFF, '{30'h0,        1'b0, 19'd2, 19'd5}},
      // Frames either side of a word boundary.
      '{1'b0, OP_ADD_USABLE, 32'h0001_F000, '0},
      '{1'b0, OP_ADD_USABLE, 32'h0002_0ABC, '0},
      '{1'b0, OP_ADD_USABLE, 32'h0000_2000, '0},
      '{1'b0, OP_ALLOCATE,   32'h0000_0000, '0},
      '{1'b0, OP_ALLOCATE,   32'h0000_0000, '0},
      '{1'b0, OP_RESERVE,    32'h0002_0000, '0},
      '{1'b0, OP_FREE,       32'h0001_F000, '0}
    };

    // Reset is released on a falling edge. The block then sweeps its bitmap,
    // with ready low, before the first request.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i]) begin
      send_request(directed_steps[i].op, directed_steps[i].addr,
                   directed_steps[i].typed, directed_steps[i].want, predicted);
    end

    // Random traffic mimics an allocator in use: usable ranges are added,
    // frames are allocated and handed back, and some frames are reserved.
    // A few requests go past the end of memory, and now and then a high frame
    // is added and at once reserved again, so that the upper address bits
    // move without leaving a far free frame for later searches to walk to.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS / 3) begin
        send_idle_pct = 54;
        recv_idle_pct = 29;
      end
      if (n == 2 * RANDOM_REQUESTS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pick   = $urandom_range(99);
      offset = $urandom_range(FRAME_BYTES - 1);
      frame  = $urandom_range(SMALL_FRAMES - 1);
      addr   = frame * FRAME_BYTES + offset;
      // Failed allocates may search the whole bitmap, so they are kept rare.
      if (pick < 30 && (open_frames != 0 || $urandom_range(4) == 0)) begin
        op   = OP_ALLOCATE;
        addr = $urandom;
      end else if (pick < 50) begin
        op = OP_FREE;
        if (granted_frames.size() != 0 && $urandom_range(3) != 0) begin
          slot = $urandom_range(granted_frames.size() - 1);
          addr = granted_frames[slot] * FRAME_BYTES + offset;
          granted_frames.delete(slot);
        end
      end else if (pick < 62) begin
        op = OP_RESERVE;
      end else if (pick < 95) begin
        op = OP_ADD_USABLE;
      end else if (pick < 97) begin
        frame = $urandom_range(FRAME_COUNT - 1, SMALL_FRAMES);
        addr  = frame * FRAME_BYTES + offset;
        send_request(OP_ADD_USABLE, addr, 1'b0, '0, predicted);
        op = OP_RESERVE;
      end else begin
        op   = OPCODE_W'($urandom_range(3, 1));
        addr = {2'($urandom_range(3, 1)), 30'($urandom)};
      end
      send_request(op, addr, 1'b0, '0, predicted);
      if (op == OP_ALLOCATE && predicted.success) begin
        granted_frames.push_back(predicted.granted_address / FRAME_BYTES);
      end
    end
    req_ch.valid <= 1'b0;

    // Wait for every outstanding result, then a little longer so that a
    // spurious extra result would still be seen.
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
